// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. All sample on clk and are
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pcev_pkg.sv =====
// ----------------------------------------------------------------------------
// pcev_pkg
// Types, codes and constants of the periodic cue event heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcev_pkg;

  localparam int MAX_CUES  = 1024;
  localparam int CUE_W     = 10;   // cue / heap slot address
  localparam int CNT_W     = 11;   // count, holds MAX_CUES itself
  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 53;
  localparam int CYCLE_W   = 48;
  localparam int ACC_W     = 128;

  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_SEEK  = 3'd1;
  localparam logic [2:0] MODE_HIST  = 3'd2;
  localparam logic [2:0] MODE_POP   = 3'd3;
  localparam logic [2:0] MODE_SHIFT = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  // Rounding offset: half a sample
  localparam logic [ACC_W-1:0] HALF = (ACC_W'(1) << FRAC_BITS) >> 1;

  typedef struct packed {
    logic [2:0]           mode;
    logic signed [63:0]   cue_start;
    logic signed [63:0]   cue_end;
    logic [62:0]          cue_period;
    logic                 is_note;
    logic [15:0]          stream_id;
    logic [SAMPLE_W-1:0]  from_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 head_valid;
    logic [SAMPLE_W-1:0]  head_time;
    logic [SAMPLE_W-1:0]  head_end_time;
    logic [CUE_W-1:0]     head_cue;
    logic [CYCLE_W-1:0]   head_cycle;
  } out_word_t;

  typedef struct packed {
    logic signed [63:0] cue_start;
    logic signed [63:0] cue_end;
    logic [62:0]        period;
    logic               note;
    logic [15:0]        stream;
  } cue_ent_t;

  // Field order is the heap ordering key, most significant first
  typedef struct packed {
    logic [SAMPLE_W-1:0] time_s;
    logic                note;
    logic [15:0]         stream;
    logic [CYCLE_W-1:0]  cycle;
    logic [CUE_W-1:0]    idx;
  } heap_ent_t;

  localparam int HEAP_W = $bits(heap_ent_t);

  typedef enum logic [4:0] {
    S_IDLE, S_SK_RD, S_SK_LD, S_SK_BS, S_SK_BSD, S_SK_PUSH, S_HP_NEXT,
    S_SD_LDC, S_SD_GETC, S_SD_LVL, S_SD_CMP, S_PP_RD, S_PP_H, S_PP_C,
    S_PP_D, S_SH_RD, S_SH_L, S_OC_MUL, S_OC_RND, S_RP_RD, S_RP_H,
    S_RP_C, S_RP_E, S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/periodic_cue_event_heap.sv =====
// ----------------------------------------------------------------------------
// periodic_cue_event_heap
// Periodic cue scheduler: cue table plus binary min-heap of next occurrences.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_stall/in_data carry one command word (add, seek, seek with
//   history, pop, shift); out_valid/out_stall/out_data return exactly one
//   word per command: a status and the current head of the heap.
//   One word is in flight at a time: in_stall stays high from acceptance
//   until the result word has been taken.
//   Occurrences are evaluated by one shared 32x32 multiplier, four partial
//   products per evaluation, followed by a rounding step.
//   Add and unused modes evaluate the head's end time when the heap is
//   non-empty and skip it when the heap is empty (as for pop/shift on an
//   empty heap); pop and shift each walk the heap level by level; seek
//   runs up to 49 bisection steps per cue plus the heap build, which sifts
//   down each inner node level by level.
//   Reset clears the cue count, the heap fill and the armed flag; the stores
//   need no clearing pass. A stalled result word holds in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module periodic_cue_event_heap
  import pcev_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  // control
  state_t              state_r, state_nxt, ret_r, sd_ret_r;
  logic [CNT_W-1:0]    total_r, used_r, c_r, hp_i_r;
  logic                armed_r;
  // item
  logic [SAMPLE_W-1:0] from_r;
  logic                hist_r;
  logic [1:0]          status_r;
  // sift / search
  logic [CUE_W-1:0]    sd_i_r;
  heap_ent_t           cur_r;
  logic [CYCLE_W:0]    lo_r, hi_r;
  // occurrence unit
  logic [CYCLE_W-1:0]  occ_k_r;
  logic [ACC_W-1:0]    acc_r;
  logic [63:0]         pp_r;
  logic [1:0]          psel_r;
  logic [2:0]          mstep_r;
  logic                occ_neg_r, occ_far_r;
  logic [SAMPLE_W-1:0] occ_smp_r;
  out_word_t           out_r;

  // memories
  cue_ent_t            cue_mem [MAX_CUES];
  heap_ent_t           heap_mem [MAX_CUES];
  cue_ent_t            cue_q;
  heap_ent_t           heap_qa, heap_qb;
  logic                cq_we, cq_re, hp_we, hp_rea, hp_reb;
  logic [CUE_W-1:0]    cq_wa, cq_ra, hp_wa, hp_raa, hp_rab;
  heap_ent_t           hp_wd;

  logic                in_acc, out_acc, add_ok, push_ok, has_l, has_r, move;
  logic                bs_more, bs_skip, reached, pop_go, adv;
  logic [CNT_W:0]      child, child1;
  logic [CYCLE_W:0]    mid, pop_k;
  heap_ent_t           pick, push_ent;
  logic [31:0]         mul_a, mul_b;
  logic [ACC_W-1:0]    pp_sh, rnd_sum;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign add_ok  = !armed_r && (total_r != CNT_W'(MAX_CUES))
                   && !(in_data.cue_end < in_data.cue_start);

  // bisection over cycles [lo, hi)
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign bs_more = lo_r < hi_r;
  assign bs_skip = hist_r ? (lo_r == '0) : lo_r[CYCLE_W];
  assign reached = !occ_neg_r && (occ_far_r || occ_smp_r >= from_r);
  assign push_ok = !occ_neg_r && !occ_far_r
                   && (hist_r ? (occ_smp_r < from_r) : (occ_smp_r >= from_r));
  assign push_ent = '{time_s: occ_smp_r, note: cue_q.note, stream: cue_q.stream,
                      cycle: occ_k_r, idx: c_r[CUE_W-1:0]};

  // sift-down children of slot sd_i_r
  assign child  = {1'b0, sd_i_r, 1'b1};
  assign child1 = child + (CNT_W+1)'(1);
  assign has_l  = child < {1'b0, used_r};
  assign has_r  = child1 < {1'b0, used_r};
  assign pick   = (has_r && (HEAP_W'(heap_qb) < HEAP_W'(heap_qa))) ? heap_qb : heap_qa;
  assign move   = HEAP_W'(pick) < HEAP_W'(cur_r);

  assign pop_k  = {1'b0, cur_r.cycle} + (CYCLE_W+1)'(1);
  assign pop_go = (cue_q.period != '0) && !pop_k[CYCLE_W];
  assign adv    = !occ_neg_r && !occ_far_r && (occ_smp_r > cur_r.time_s);

  // shared multiplier: partial product per step, k split 32/16, period 32/31
  assign mul_a = mstep_r[0] ? {16'b0, occ_k_r[CYCLE_W-1:32]} : occ_k_r[31:0];
  assign mul_b = mstep_r[1] ? {1'b0, cue_q.period[62:32]} : cue_q.period[31:0];

  always_comb begin
    unique case (psel_r)
      2'd0:    pp_sh = {64'b0, pp_r};
      2'd3:    pp_sh = {pp_r, 64'b0};
      default: pp_sh = {32'b0, pp_r, 32'b0};
    endcase
  end

  assign rnd_sum = acc_r + HALF;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_data.mode == MODE_SEEK || in_data.mode == MODE_HIST)
            state_nxt = S_SK_RD;
          else if (in_data.mode == MODE_POP && used_r != '0)
            state_nxt = S_PP_RD;
          else if (in_data.mode == MODE_SHIFT && used_r != '0)
            state_nxt = S_SH_RD;
          else
            state_nxt = S_RP_RD;
        end
      end
      S_SK_RD:   state_nxt = (c_r == total_r) ? S_HP_NEXT : S_SK_LD;
      S_SK_LD:   state_nxt = (cue_q.period == '0) ? S_OC_MUL : S_SK_BS;
      S_SK_BS:   state_nxt = (!bs_more && bs_skip) ? S_SK_RD : S_OC_MUL;
      S_SK_BSD:  state_nxt = S_SK_BS;
      S_SK_PUSH: state_nxt = S_SK_RD;
      S_HP_NEXT: state_nxt = (hp_i_r == '0) ? S_RP_RD : S_SD_LDC;
      S_SD_LDC:  state_nxt = S_SD_GETC;
      S_SD_GETC: state_nxt = S_SD_LVL;
      S_SD_LVL:  state_nxt = has_l ? S_SD_CMP : sd_ret_r;
      S_SD_CMP:  state_nxt = move ? S_SD_LVL : sd_ret_r;
      S_PP_RD:   state_nxt = S_PP_H;
      S_PP_H:    state_nxt = S_PP_C;
      S_PP_C:    state_nxt = pop_go ? S_OC_MUL : S_SH_RD;
      S_PP_D:    state_nxt = adv ? S_SD_LVL : S_SH_RD;
      S_SH_RD:   state_nxt = S_SH_L;
      S_SH_L:    state_nxt = (used_r == '0) ? S_RP_RD : S_SD_LVL;
      S_OC_MUL:  state_nxt = (mstep_r == 3'd4) ? S_OC_RND : S_OC_MUL;
      S_OC_RND:  state_nxt = ret_r;
      S_RP_RD:   state_nxt = (used_r == '0) ? S_OUT : S_RP_H;
      S_RP_H:    state_nxt = S_RP_C;
      S_RP_C:    state_nxt = S_OC_MUL;
      S_RP_E:    state_nxt = S_OUT;
      S_OUT:     state_nxt = out_acc ? S_IDLE : S_OUT;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs and memory strobes
  always_comb begin
    in_stall = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
    cq_we  = 1'b0;
    cq_wa  = total_r[CUE_W-1:0];
    cq_re  = 1'b0;
    cq_ra  = c_r[CUE_W-1:0];
    hp_we  = 1'b0;
    hp_wa  = sd_i_r;
    hp_wd  = cur_r;
    hp_rea = 1'b0;
    hp_reb = 1'b0;
    hp_raa = '0;
    hp_rab = '0;
    unique case (state_r)
      S_IDLE:    cq_we = in_acc && (in_data.mode == MODE_ADD) && add_ok;
      S_SK_RD:   cq_re = (c_r != total_r);
      S_SK_PUSH: begin
        hp_we = push_ok;
        hp_wa = used_r[CUE_W-1:0];
        hp_wd = push_ent;
      end
      S_SD_LDC: begin
        hp_rea = 1'b1;
        hp_raa = sd_i_r;
      end
      S_SD_LVL: begin
        if (has_l) begin
          hp_rea = 1'b1;
          hp_reb = 1'b1;
          hp_raa = child[CUE_W-1:0];
          hp_rab = child1[CUE_W-1:0];
        end else begin
          hp_we = 1'b1;
        end
      end
      S_SD_CMP: begin
        hp_we = 1'b1;
        hp_wd = move ? pick : cur_r;
      end
      S_PP_RD, S_RP_RD: hp_rea = 1'b1;
      S_PP_H, S_RP_H: begin
        cq_re = 1'b1;
        cq_ra = heap_qa.idx;
      end
      S_SH_RD: begin
        hp_rea = 1'b1;
        hp_raa = CUE_W'(used_r - CNT_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cq_we) cue_mem[cq_wa] <= '{cue_start: in_data.cue_start, cue_end: in_data.cue_end,
                                   period: in_data.cue_period, note: in_data.is_note,
                                   stream: in_data.stream_id};
    if (cq_re) cue_q <= cue_mem[cq_ra];
  end

  always_ff @(posedge clk) begin
    if (hp_we)  heap_mem[hp_wa] <= hp_wd;
    if (hp_rea) heap_qa <= heap_mem[hp_raa];
    if (hp_reb) heap_qb <= heap_mem[hp_rab];
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      used_r  <= '0;
      armed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            from_r   <= in_data.from_time;
            hist_r   <= (in_data.mode == MODE_HIST);
            c_r      <= '0;
            priority if (in_data.mode == MODE_ADD) begin
              if (add_ok) begin
                total_r  <= total_r + CNT_W'(1);
                status_r <= ST_OK;
              end else begin
                status_r <= ST_REJECT;
              end
            end else if (in_data.mode == MODE_SEEK || in_data.mode == MODE_HIST) begin
              armed_r  <= 1'b1;
              used_r   <= '0;
              status_r <= ST_OK;
            end else if ((in_data.mode == MODE_POP || in_data.mode == MODE_SHIFT)
                         && used_r == '0) begin
              status_r <= ST_EMPTY;
            end else begin
              status_r <= ST_OK;
            end
          end
        end
        S_SK_RD: hp_i_r <= used_r >> 1;
        S_SK_LD: begin
          lo_r <= '0;
          hi_r <= (CYCLE_W+1)'(1) << CYCLE_W;
          if (cue_q.period == '0) begin
            occ_k_r <= '0;
            acc_r   <= ACC_W'(cue_q.cue_start);
            mstep_r <= '0;
            ret_r   <= S_SK_PUSH;
          end
        end
        S_SK_BS: begin
          mstep_r <= '0;
          acc_r   <= ACC_W'(cue_q.cue_start);
          if (bs_more) begin
            occ_k_r <= mid[CYCLE_W-1:0];
            ret_r   <= S_SK_BSD;
          end else if (bs_skip) begin
            c_r <= c_r + CNT_W'(1);
          end else begin
            occ_k_r <= hist_r ? CYCLE_W'(lo_r - (CYCLE_W+1)'(1)) : lo_r[CYCLE_W-1:0];
            ret_r   <= S_SK_PUSH;
          end
        end
        S_SK_BSD: begin
          if (reached) hi_r <= {1'b0, occ_k_r};
          else         lo_r <= {1'b0, occ_k_r} + (CYCLE_W+1)'(1);
        end
        S_SK_PUSH: begin
          if (push_ok) used_r <= used_r + CNT_W'(1);
          c_r <= c_r + CNT_W'(1);
        end
        S_HP_NEXT: begin
          if (hp_i_r != '0) begin
            hp_i_r   <= hp_i_r - CNT_W'(1);
            sd_i_r   <= CUE_W'(hp_i_r - CNT_W'(1));
            sd_ret_r <= S_HP_NEXT;
          end
        end
        S_SD_GETC: cur_r <= heap_qa;
        S_SD_CMP: begin
          if (move) sd_i_r <= (has_r && (HEAP_W'(heap_qb) < HEAP_W'(heap_qa)))
                              ? child1[CUE_W-1:0] : child[CUE_W-1:0];
        end
        S_PP_H: cur_r <= heap_qa;
        S_PP_C: begin
          occ_k_r <= pop_k[CYCLE_W-1:0];
          acc_r   <= ACC_W'(cue_q.cue_start);
          mstep_r <= '0;
          ret_r   <= S_PP_D;
        end
        S_PP_D: begin
          if (adv) begin
            cur_r.time_s <= occ_smp_r;
            cur_r.cycle  <= occ_k_r;
            sd_i_r       <= '0;
            sd_ret_r     <= S_RP_RD;
          end
        end
        S_SH_RD: used_r <= used_r - CNT_W'(1);
        S_SH_L: begin
          cur_r    <= heap_qa;
          sd_i_r   <= '0;
          sd_ret_r <= S_RP_RD;
        end
        S_OC_MUL: begin
          if (mstep_r != 3'd4) begin
            pp_r   <= 64'(mul_a) * 64'(mul_b);
            psel_r <= mstep_r[1:0];
          end
          if (mstep_r != '0) acc_r <= acc_r + pp_sh;
          mstep_r <= mstep_r + 3'd1;
        end
        S_OC_RND: begin
          occ_neg_r <= acc_r[ACC_W-1];
          occ_far_r <= (rnd_sum >> (FRAC_BITS + SAMPLE_W)) != '0;
          occ_smp_r <= rnd_sum[FRAC_BITS +: SAMPLE_W];
        end
        S_RP_RD: begin
          out_r <= '{status: status_r, head_valid: 1'b0, head_time: '0,
                     head_end_time: '0, head_cue: '0, head_cycle: '0};
        end
        S_RP_H: cur_r <= heap_qa;
        S_RP_C: begin
          occ_k_r <= cur_r.cycle;
          acc_r   <= ACC_W'(cue_q.cue_end);
          mstep_r <= '0;
          ret_r   <= S_RP_E;
        end
        S_RP_E: begin
          out_r.head_valid <= 1'b1;
          out_r.head_time  <= cur_r.time_s;
          out_r.head_cue   <= cur_r.idx;
          out_r.head_cycle <= cur_r.cycle;
          out_r.head_end_time <= occ_neg_r ? '0 : (occ_far_r ? '1 : occ_smp_r);
        end
        default: ;
      endcase
    end
  end

  assign out_data = out_r;

  `ASSERT_ALWAYS(a_used_le_total, used_r <= total_r, "heap holds more cursors than cues")
  `ASSERT_ALWAYS(a_total_max, total_r <= CNT_W'(MAX_CUES), "cue count beyond table size")
  `ASSERT_ALWAYS(a_one_in_flight, !out_valid || in_stall, "input open while result pending")
  `ASSERT_NEXT(a_add_armed,
               in_valid && !in_stall && in_data.mode == MODE_ADD && armed_r,
               $stable(total_r), "cue added after seek")
  `ASSERT_NEXT(a_accept_stalls, in_valid && !in_stall, in_stall,
               "input not stalled after accepting a word")

endmodule

`default_nettype wire
